@@ sv/slt_pkg.sv @@
// Shared types and codes for the stack-language tokenizer.
package slt_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 16;

	localparam int KIND_W = 3;
	localparam int ERR_W  = 3;
	localparam int POS_W  = 24;
	localparam int LC_W   = 16;

	localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STRING  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WORD    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INCLUDE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
	localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_OPEN_STRING  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_BAD_INCLUDE  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_OPEN_COMMENT = 3'd4;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] next_ch;
		logic       at_end;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [POS_W-1:0]  token_start;
		logic [POS_W-1:0]  token_length;
		logic [ERR_W-1:0]  error_code;
		logic [LC_W-1:0]   line;
		logic [LC_W-1:0]   column;
	} result_t;

endpackage

@@ sv/slt_lexer.sv @@
// Lexer state registers and the per-byte mode transition.
module slt_lexer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  slt_pkg::item_t  item,
	output logic            res_valid,
	output slt_pkg::result_t res
);
	import slt_pkg::*;

	typedef enum logic [2:0] {
		M_BLANK, M_NUMBER, M_STRING, M_WORD, M_COMMENT, M_INCLUDE, M_HALTED
	} mode_t;

	localparam logic [LINE_BITS-1:0] LC_MAX = {LINE_BITS{1'b1}};

	mode_t                  mode_q, mode_d;
	logic                   is_line_q, is_line_d;
	logic [OFFSET_BITS-1:0] begin_q, begin_d;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [LINE_BITS-1:0]   line_q, col_q;

	logic                   eof, newline, blank, c_digit, nx_digit, emit, count_ok;
	logic [7:0]             c, nx;
	logic [ERR_W-1:0]       err;
	logic [KIND_W-1:0]      kind;
	logic [OFFSET_BITS-1:0] start, len, begin_p1;

	always_comb begin
		eof      = item.at_end;
		c        = eof ? 8'd0 : item.ch;
		nx       = (eof || c == 8'd0) ? 8'd0 : item.next_ch;
		newline  = (c == 8'h0A) || (c == 8'h0D);
		blank    = (c == 8'h20) || newline || eof;
		c_digit  = (c >= 8'h30) && (c <= 8'h39);
		nx_digit = (nx >= 8'h30) && (nx <= 8'h39);
		begin_p1 = begin_q + OFFSET_BITS'(1);

		mode_d    = mode_q;
		is_line_d = is_line_q;
		begin_d   = begin_q;
		err       = ERR_NONE;
		emit      = 1'b0;
		kind      = KIND_WORD;
		start     = begin_q;
		len       = offset_q - begin_q;
		count_ok  = 1'b1;

		case (mode_q)
			M_BLANK: begin
				if (blank) begin
					mode_d = M_BLANK;
				end else if (c == "/" && nx == "/") begin
					mode_d    = M_COMMENT;
					is_line_d = 1'b1;
				end else if (c == "(") begin
					mode_d    = M_COMMENT;
					is_line_d = 1'b0;
				end else if (c == "{") begin
					mode_d  = M_INCLUDE;
					begin_d = offset_q;
				end else if ((c == "-" && (nx_digit || nx == ".")) || c == "." || c_digit) begin
					mode_d  = M_NUMBER;
					begin_d = offset_q;
				end else if (c == "\"") begin
					mode_d  = M_STRING;
					begin_d = offset_q;
				end else if (c >= 8'h21 && c <= 8'h7E) begin
					mode_d  = M_WORD;
					begin_d = offset_q;
				end else begin
					err = ERR_UNEXPECTED;
				end
			end
			M_NUMBER, M_WORD: begin
				if (blank) begin
					emit   = 1'b1;
					kind   = (mode_q == M_NUMBER) ? KIND_NUMBER : KIND_WORD;
					mode_d = M_BLANK;
				end
			end
			M_STRING: begin
				if (eof) begin
					err = ERR_OPEN_STRING;
				end else if (c == "\"") begin
					emit   = 1'b1;
					kind   = KIND_STRING;
					start  = begin_p1;
					len    = offset_q - begin_p1;
					mode_d = M_BLANK;
				end
			end
			M_INCLUDE: begin
				if (newline || eof) begin
					err = ERR_BAD_INCLUDE;
				end else if (c == "}") begin
					emit   = 1'b1;
					kind   = KIND_INCLUDE;
					start  = begin_p1;
					len    = offset_q - begin_p1;
					mode_d = M_BLANK;
				end
			end
			M_COMMENT: begin
				if (is_line_q) begin
					if (newline) mode_d = M_BLANK;
				end else if (c == ")") begin
					mode_d = M_BLANK;
				end else if (eof) begin
					err = ERR_OPEN_COMMENT;
				end
			end
			default: begin
				// halted, or a code that never occurs: freeze
				mode_d   = M_HALTED;
				count_ok = 1'b0;
			end
		endcase

		if (err != ERR_NONE) begin
			emit     = 1'b1;
			kind     = KIND_ERROR;
			start    = offset_q;
			len      = '0;
			mode_d   = M_HALTED;
			count_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_BLANK;
			is_line_q <= 1'b0;
			begin_q   <= '0;
			offset_q  <= '0;
			line_q    <= LINE_BITS'(1);
			col_q     <= LINE_BITS'(1);
		end else if (fire) begin
			mode_q    <= mode_d;
			is_line_q <= is_line_d;
			begin_q   <= begin_d;
			if (count_ok) begin
				offset_q <= offset_q + OFFSET_BITS'(1);
				if (c == 8'h0A) begin
					col_q <= LINE_BITS'(1);
					if (line_q < LC_MAX) line_q <= line_q + LINE_BITS'(1);
				end else if (col_q < LC_MAX) begin
					col_q <= col_q + LINE_BITS'(1);
				end
			end
		end
	end

	assign res_valid        = fire && emit;
	assign res.token_kind   = kind;
	assign res.token_start  = POS_W'(start);
	assign res.token_length = POS_W'(len);
	assign res.error_code   = err;
	assign res.line         = LC_W'(line_q);
	assign res.column       = LC_W'(col_q);

endmodule

@@ sv/slt_out_reg.sv @@
// Result register holding one token beat until the receiver takes it.
module slt_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  slt_pkg::result_t din,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             free,
	output slt_pkg::result_t dout
);
	import slt_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign dout      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= din;
	end

endmodule

@@ sv/stack_language_tokenizer_top.sv @@
// Top level of the stack-language tokenizer.
// Usage:
//   Input channel (in_valid/in_ready) carries one source byte per beat: ch,
//   the lookahead byte next_ch and the end mark at_end.
//   Output channel (out_valid/out_ready) carries one token or error beat:
//   token_kind, token_start, token_length, error_code, line, column.
//   Only bytes that close a token, or fail, produce an output beat.
// Path: a byte is taken into the input register, evaluated against the
//   lexer state, and a resulting beat is loaded into the output register.
// Throughput: one byte per cycle while out_ready is high; the lexer state
//   is updated once per byte, so back-to-back bytes flow freely.
// Stall: while the output register holds an untaken beat the staged byte
//   waits, and in_ready drops once the input register is also full.
// Reset (arst_n low): blank mode, offset 0, line 1, column 1, both
//   registers empty. After an error beat the block halts: later bytes are
//   taken and dropped until the next reset.
module stack_language_tokenizer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  ch,
	input  logic [7:0]                  next_ch,
	input  logic                        at_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [slt_pkg::KIND_W-1:0]  token_kind,
	output logic [slt_pkg::POS_W-1:0]   token_start,
	output logic [slt_pkg::POS_W-1:0]   token_length,
	output logic [slt_pkg::ERR_W-1:0]   error_code,
	output logic [slt_pkg::LC_W-1:0]    line,
	output logic [slt_pkg::LC_W-1:0]    column
);
	import slt_pkg::*;

	logic    valid_s1, advance, res_valid, out_free;
	item_t   item_s1;
	result_t res, res_q;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.ch      <= ch;
			item_s1.next_ch <= next_ch;
			item_s1.at_end  <= at_end;
		end
	end

	slt_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	slt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.din       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (out_free),
		.dout      (res_q)
	);

	assign token_kind   = res_q.token_kind;
	assign token_start  = res_q.token_start;
	assign token_length = res_q.token_length;
	assign error_code   = res_q.error_code;
	assign line         = res_q.line;
	assign column       = res_q.column;

endmodule

@@ sv/slt_checker.sv @@
// Port-level checks for the tokenizer, bound to the top level.
module slt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [slt_pkg::KIND_W-1:0]  token_kind,
	input logic [slt_pkg::POS_W-1:0]   token_start,
	input logic [slt_pkg::ERR_W-1:0]   error_code,
	input logic [slt_pkg::LC_W-1:0]    line,
	input logic [slt_pkg::LC_W-1:0]    column
);
	import slt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_start))
		else $error("output beat changed while stalled");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((token_kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match token kind");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && token_kind == KIND_ERROR |=> !out_valid)
		else $error("beat after an error");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line != '0 && column != '0)
		else $error("line or column is zero");

endmodule

bind stack_language_tokenizer_top slt_checker u_slt_checker (.*);
